### rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int ADDR_W            = 48;
  localparam int MAX_ORDER_DEF     = 10;
  localparam int PAGE_BYTES_DEF    = 4096;
  localparam int LIST_CAPACITY_DEF = 256;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_SEED  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [0:0] REG_RESERVED = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_RD,
    S_ALLOC_WAIT,
    S_SPLIT,
    S_FREE_LVL,
    S_FREE_SRCH,
    S_FREE_CMP,
    S_FREE_CHK,
    S_RM_LVL,
    S_RM_RD,
    S_RM_WR,
    S_FREE_PUSH,
    S_SEED,
    S_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
  endfunction

endpackage

### rtl/bpa_if.sv
// Valid/ready channels for request items and result items.
// Depends on bpa_pkg for the address width.
`timescale 1ns / 1ps

interface bpa_in_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [3:0]        order;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] length;
  logic              use_reserve;

  modport source (output valid, opcode, order, address, length, use_reserve, input ready);
  modport sink (input valid, opcode, order, address, length, use_reserve, output ready);
endinterface

interface bpa_out_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] block_address;
  logic [ADDR_W-1:0] free_bytes_now;

  modport source (output valid, status, block_address, free_bytes_now, input ready);
  modport sink (input valid, status, block_address, free_bytes_now, output ready);
endinterface

### rtl/bpa_store.sv
// Free block store: simple dual-port RAM, one write and one registered read.
// Depends on bpa_pkg only through the import convention.
`timescale 1ns / 1ps

module bpa_store import bpa_pkg::*; #(
  parameter int DEPTH = 2816,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/buddy_page_allocator_top.sv
// Allocate checks the lists, reads a block and splits it down order by order; a refused one ends
// without a read. Free compares list entries for the buddy, merges, shifts entries on removal
// and pushes the block; seed stores aligned blocks one after another. One item is in work at a
// time; the result register lets the next item in while a result waits. The free list scan and
// removal shift through the single RAM read port set the rate. Reset (synchronous, active low)
// clears list counts, tallies and the reserve register; the block store needs no clearing pass.
`timescale 1ns / 1ps

module buddy_page_allocator_top import bpa_pkg::*; #(
  parameter int MAX_ORDER     = MAX_ORDER_DEF,
  parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NO  = MAX_ORDER + 1;
  localparam int OW  = $clog2(NO);
  localparam int PS  = $clog2(PAGE_BYTES);
  localparam int PNW = ADDR_W - PS;
  localparam int CW  = $clog2(LIST_CAPACITY + 1);
  localparam int IW  = $clog2(LIST_CAPACITY);
  localparam int DEPTH = NO * LIST_CAPACITY;
  localparam int AW  = $clog2(DEPTH);
  localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

  function automatic logic [AW-1:0] maddr(input logic [OW-1:0] k, input logic [IW-1:0] i);
    return AW'(AW'(k) * AW'(LIST_CAPACITY)) + AW'(i);
  endfunction

  function automatic logic [ADDR_W-1:0] bb(input logic [OW-1:0] k);
    return ADDR_W'(PAGE_BYTES) << k;
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r [NO];
  logic [IW-1:0]     idx_r [NO];
  logic [OW-1:0]     ord_r, k_r, f_r, j_r;
  logic              allow_r;
  logic [PNW-1:0]    pn_r;
  logic [CW-1:0]     ptr_r;
  logic [PNW:0]      a_r, end_r;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] blk_r;
  logic [ADDR_W-1:0] free_tally_r, mng_tally_r, reserved_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_blk_r, out_free_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [PNW-1:0]    mem_wdata, mem_rdata;

  bpa_store #(.DEPTH(DEPTH), .WIDTH(PNW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3:3] == REG_RESERVED) ? {16'd0, reserved_r} : 64'd0;

  // Allocation search and checks
  logic          alloc_found, split_full, reserve_fail;
  logic [OW-1:0] f_c;
  logic [ADDR_W:0] need;

  always_comb begin
    alloc_found = 1'b0;
    f_c         = '0;
    split_full  = 1'b0;
    for (int k = 0; k < NO; k++) begin
      if (!alloc_found && OW'(k) >= ord_r && cnt_r[k] != '0) begin
        alloc_found = 1'b1;
        f_c         = OW'(k);
      end
    end
    for (int k = 0; k < NO; k++) begin
      if (OW'(k) >= ord_r && OW'(k) < f_c && cnt_r[k] >= CAP) begin
        split_full = 1'b1;
      end
    end
    need         = {1'b0, bb(f_c)} + {1'b0, reserved_r};
    reserve_fail = !allow_r && ({1'b0, free_tally_r} < need);
  end

  // Seed: largest aligned block that fits in the remaining range
  logic [PNW:0]  seed_rem;
  logic [OW-1:0] seed_k;
  logic          seed_stop;

  always_comb begin
    seed_rem  = end_r - a_r;
    seed_k    = '0;
    seed_stop = 1'b0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (!seed_stop) begin
        if ((seed_rem >> (k + 1)) == '0 || a_r[k]) begin
          seed_stop = 1'b1;
        end else begin
          seed_k = OW'(k + 1);
        end
      end
    end
  end

  logic [PNW-1:0] buddy_pn;
  assign buddy_pn = pn_r ^ (PNW'(1) << k_r);

  logic in_acc, out_load;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.opcode)
            OP_ALLOC: state_nxt = (int'(in_ch.order) > MAX_ORDER) ? S_DONE : S_ALLOC_CHK;
            OP_FREE:  state_nxt = (int'(in_ch.order) > MAX_ORDER) ? S_DONE : S_FREE_LVL;
            OP_SEED:  state_nxt = S_SEED;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_ALLOC_CHK:  state_nxt = (!alloc_found || reserve_fail || split_full) ? S_DONE
                                                                             : S_ALLOC_RD;
      S_ALLOC_RD:   state_nxt = S_ALLOC_WAIT;
      S_ALLOC_WAIT: state_nxt = S_SPLIT;
      S_SPLIT:      state_nxt = (k_r == ord_r) ? S_DONE : S_SPLIT;
      S_FREE_LVL:   state_nxt = (int'(k_r) == MAX_ORDER) ? S_FREE_CHK : S_FREE_SRCH;
      S_FREE_SRCH:  state_nxt = (ptr_r == '0) ? S_FREE_CHK : S_FREE_CMP;
      S_FREE_CMP:   state_nxt = (mem_rdata == buddy_pn) ? S_FREE_LVL : S_FREE_SRCH;
      S_FREE_CHK:   state_nxt = (cnt_r[k_r] >= CAP) ? S_DONE : S_RM_LVL;
      S_RM_LVL:     state_nxt = (j_r == k_r) ? S_FREE_PUSH : S_RM_RD;
      S_RM_RD:      state_nxt = (ptr_r >= cnt_r[j_r]) ? S_RM_LVL : S_RM_WR;
      S_RM_WR:      state_nxt = S_RM_RD;
      S_FREE_PUSH:  state_nxt = S_DONE;
      S_SEED: begin
        if (a_r >= end_r || cnt_r[seed_k] >= CAP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:       state_nxt = out_load ? S_IDLE : S_DONE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and RAM controls
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    unique case (state_r)
      S_ALLOC_RD: mem_raddr = maddr(f_r, cnt_r[f_r][IW-1:0]);
      S_SPLIT: begin
        if (k_r != ord_r) begin
          mem_we    = 1'b1;
          mem_waddr = maddr(k_r - 1'b1, cnt_r[k_r - 1'b1][IW-1:0]);
          mem_wdata = pn_r + (PNW'(1) << (k_r - 1'b1));
        end
      end
      S_FREE_SRCH: mem_raddr = maddr(k_r, IW'(ptr_r - 1'b1));
      S_RM_RD:     mem_raddr = maddr(j_r, ptr_r[IW-1:0]);
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(j_r, IW'(ptr_r - 1'b1));
        mem_wdata = mem_rdata;
      end
      S_FREE_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(k_r, cnt_r[k_r][IW-1:0]);
        mem_wdata = pn_r;
      end
      S_SEED: begin
        if (a_r < end_r && cnt_r[seed_k] < CAP) begin
          mem_we    = 1'b1;
          mem_waddr = maddr(seed_k, cnt_r[seed_k][IW-1:0]);
          mem_wdata = a_r[PNW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Seed range bounds in bytes, the start biased to round up to a whole page
  logic [ADDR_W:0] seed_end_b, seed_start_b;
  assign seed_end_b   = {1'b0, in_ch.address} + {1'b0, in_ch.length};
  assign seed_start_b = {1'b0, in_ch.address} + (ADDR_W + 1)'(PAGE_BYTES - 1);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_tally_r <= '0;
      mng_tally_r  <= '0;
      reserved_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NO; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[3:3] == REG_RESERVED) begin
        reserved_r <= cfg_pwdata[ADDR_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_ALLOC_CHK: begin
          if (alloc_found && !reserve_fail && !split_full) begin
            cnt_r[f_c] <= cnt_r[f_c] - 1'b1;
          end
        end
        S_SPLIT: begin
          if (k_r != ord_r) begin
            cnt_r[k_r - 1'b1] <= cnt_r[k_r - 1'b1] + 1'b1;
          end else begin
            free_tally_r <= (free_tally_r >= bb(ord_r)) ? free_tally_r - bb(ord_r) : '0;
          end
        end
        S_RM_RD: begin
          if (ptr_r >= cnt_r[j_r]) begin
            cnt_r[j_r] <= cnt_r[j_r] - 1'b1;
          end
        end
        S_FREE_PUSH: begin
          cnt_r[k_r]   <= cnt_r[k_r] + 1'b1;
          free_tally_r <= sat_add(free_tally_r, bb(ord_r));
        end
        S_SEED: begin
          if (a_r < end_r && cnt_r[seed_k] < CAP) begin
            cnt_r[seed_k] <= cnt_r[seed_k] + 1'b1;
            free_tally_r  <= sat_add(free_tally_r, bb(seed_k));
            mng_tally_r   <= sat_add(mng_tally_r, bb(seed_k));
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ord_r    <= OW'(in_ch.order);
          k_r      <= OW'(in_ch.order);
          allow_r  <= in_ch.use_reserve;
          pn_r     <= in_ch.address[ADDR_W-1:PS];
          blk_r    <= '0;
          a_r      <= seed_start_b[ADDR_W:PS];
          end_r    <= seed_end_b[ADDR_W] ? ((PNW + 1)'(1) << PNW)
                                         : {1'b0, seed_end_b[ADDR_W-1:PS]};
          status_r <= (in_ch.opcode == OP_ALLOC && int'(in_ch.order) > MAX_ORDER)
                      ? ST_NOMEM : ST_OK;
        end
      end
      S_ALLOC_CHK: begin
        f_r <= f_c;
        if (!alloc_found || reserve_fail) begin
          status_r <= ST_NOMEM;
        end else if (split_full) begin
          status_r <= ST_OVERFLOW;
        end
      end
      S_ALLOC_WAIT: begin
        pn_r <= mem_rdata;
        k_r  <= f_r;
      end
      S_SPLIT: begin
        if (k_r != ord_r) begin
          k_r <= k_r - 1'b1;
        end else begin
          blk_r <= {pn_r, {PS{1'b0}}};
        end
      end
      S_FREE_LVL:  ptr_r <= cnt_r[k_r];
      S_FREE_SRCH: ptr_r <= ptr_r - 1'b1;
      S_FREE_CMP: begin
        if (mem_rdata == buddy_pn) begin
          idx_r[k_r] <= ptr_r[IW-1:0];
          pn_r       <= pn_r & ~(PNW'(1) << k_r);
          k_r        <= k_r + 1'b1;
        end
      end
      S_FREE_CHK: begin
        j_r <= ord_r;
        if (cnt_r[k_r] >= CAP) begin
          status_r <= ST_OVERFLOW;
        end
      end
      S_RM_LVL: ptr_r <= CW'(idx_r[j_r]) + 1'b1;
      S_RM_RD: begin
        if (ptr_r >= cnt_r[j_r]) begin
          j_r <= j_r + 1'b1;
        end
      end
      S_RM_WR: ptr_r <= ptr_r + 1'b1;
      S_SEED: begin
        if (a_r < end_r) begin
          if (cnt_r[seed_k] >= CAP) begin
            status_r <= ST_OVERFLOW;
          end else begin
            a_r <= a_r + ((PNW + 1)'(1) << seed_k);
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_r <= status_r;
      out_blk_r    <= (status_r == ST_OK) ? blk_r : '0;
      out_free_r   <= free_tally_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.block_address  = out_blk_r;
  assign out_ch.free_bytes_now = out_free_r;

  a_split_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (k_r >= ord_r))
    else $error("split order fell below the requested order");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("store written outside an operation");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE_PUSH) |-> (cnt_r[k_r] < CAP))
    else $error("merged push into a full list");

  a_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_blk_r == '0))
    else $error("block address on a failed item");

endmodule
